[rtl/mmu_pkg.sv]
`timescale 1ns / 1ps

package mmu_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_PORT_W = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam int PROD_W     = 32;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  localparam logic [CFG_ADDR_W-1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COLS_OF_B  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[rtl/mmu_if.sv]
`timescale 1ns / 1ps

interface mmu_item_if import mmu_pkg::*; #(
  parameter int ELEM_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic [IDX_PORT_W-1:0]        row_index;
  logic [IDX_PORT_W-1:0]        col_index;
  logic signed [ELEM_WIDTH-1:0] element_value;

  modport source (output valid, command, row_index, col_index, element_value, input ready);
  modport sink   (input valid, command, row_index, col_index, element_value, output ready);
endinterface

interface mmu_result_if import mmu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_PORT_W-1:0]    out_row;
  logic [IDX_PORT_W-1:0]    out_col;
  logic signed [PROD_W-1:0] product_value;
  logic                     last;

  modport source (output valid, out_row, out_col, product_value, last, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

interface mmu_cfg_if import mmu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/mmu_store.sv]
`timescale 1ns / 1ps

module mmu_store #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int Depth = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mmu_mac.sv]
`timescale 1ns / 1ps

module mmu_mac import mmu_pkg::*; #(
  parameter int ELEM_WIDTH = 16,
  parameter int IDX_W      = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic [ELEM_WIDTH-1:0]    a_data,
  input  logic [ELEM_WIDTH-1:0]    b_data,
  output logic                     done,
  output logic signed [PROD_W-1:0] result
);

  localparam int MulW = 2 * ELEM_WIDTH;
  localparam int AccW = MulW + IDX_W + 1;

  mac_ctl_t                 ctl_d1;
  mac_ctl_t                 ctl_d2;
  logic signed [MulW-1:0]   prod;
  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   sum;
  logic signed [AccW-1:0]   acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d1 <= '0;
      ctl_d2 <= '0;
      done   <= 1'b0;
    end else begin
      ctl_d1 <= ctl;
      ctl_d2 <= ctl_d1;
      done   <= ctl_d2.valid && ctl_d2.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
    if (ctl_d2.valid) begin
      acc <= acc_next;
    end
  end

  assign sum = (ctl_d2.first ? AccW'(0) : acc) + AccW'(prod);

  // Very wide elements keep the running sum within plus or minus 2^61.
  generate
    if (MulW - 2 + IDX_W > 61) begin : g_clamp
      localparam logic signed [AccW-1:0] AccBound = AccW'(1) << 61;
      always_comb begin
        if (sum > AccBound) begin
          acc_next = AccBound;
        end else if (sum < -AccBound) begin
          acc_next = -AccBound;
        end else begin
          acc_next = sum;
        end
      end
    end else begin : g_noclamp
      assign acc_next = sum;
    end
  endgenerate

  generate
    if (AccW > PROD_W) begin : g_sat
      localparam logic signed [AccW-1:0] SatHi = (AccW'(1) << (PROD_W - 1)) - AccW'(1);
      localparam logic signed [AccW-1:0] SatLo = -(AccW'(1) << (PROD_W - 1));
      always_comb begin
        if (acc > SatHi) begin
          result = PROD_W'(SatHi);
        end else if (acc < SatLo) begin
          result = PROD_W'(SatLo);
        end else begin
          result = PROD_W'(acc);
        end
      end
    end else begin : g_ext
      assign result = PROD_W'(acc);
    end
  endgenerate

endmodule

[rtl/mmu_seq.sv]
`timescale 1ns / 1ps

module mmu_seq import mmu_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int IDX_W   = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [CFG_DATA_W-1:0] rows_of_a,
  input  logic [CFG_DATA_W-1:0] inner_size,
  input  logic [CFG_DATA_W-1:0] cols_of_b,
  input  logic                  acc_done,
  input  logic                  out_free,
  output logic                  idle,
  output logic [2*IDX_W-1:0]    a_raddr,
  output logic [2*IDX_W-1:0]    b_raddr,
  output mac_ctl_t              ctl,
  output logic                  emit,
  output logic [IDX_W-1:0]      cur_row,
  output logic [IDX_W-1:0]      cur_col,
  output logic                  emit_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] lim_m;
  logic [IDX_W-1:0] lim_n;
  logic [IDX_W-1:0] lim_p;

  // A dimension of zero acts as one, anything above the store size as the store size.
  function automatic logic [IDX_W-1:0] lim_of(input logic [CFG_DATA_W-1:0] r);
    logic [IDX_W-1:0] v;
    if (r == '0) begin
      v = '0;
    end else if (32'(r) > MAX_DIM) begin
      v = IDX_W'(MAX_DIM - 1);
    end else begin
      v = IDX_W'(r - 1'b1);
    end
    return v;
  endfunction

  assign idle      = (state == S_IDLE);
  assign a_raddr   = {i, k};
  assign b_raddr   = {k, j};
  assign ctl.valid = (state == S_RUN);
  assign ctl.first = (k == '0);
  assign ctl.last  = (k == lim_n);
  assign emit      = (state == S_EMIT) && out_free;
  assign cur_row   = i;
  assign cur_col   = j;
  assign emit_last = (i == lim_m) && (j == lim_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      lim_m <= '0;
      lim_n <= '0;
      lim_p <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            lim_m <= lim_of(rows_of_a);
            lim_n <= lim_of(inner_size);
            lim_p <= lim_of(cols_of_b);
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (k == lim_n) begin
            k     <= '0;
            state <= S_WAIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_WAIT: begin
          if (acc_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (j == lim_p) begin
              j <= '0;
              if (i == lim_m) begin
                state <= S_IDLE;
              end else begin
                i     <= i + 1'b1;
                state <= S_RUN;
              end
            end else begin
              j     <= j + 1'b1;
              state <= S_RUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/matrix_multiply_unit.sv]
`timescale 1ns / 1ps

// Channel  Role  Payload
// item     sink  command, row_index, col_index, element_value
// result   src   out_row, out_col, product_value, last
// cfg      sink  addr (register index), data
//
// A load request is written to its store and the block stays ready for the next request.
// A compute request runs on the single shared multiply-accumulate pipeline: issue,
// store read, multiply, accumulate, then the sum is handed to the output register.
// Reset is synchronous, clears control and returns the dimension registers to eight;
// the stores hold no reset value. A stalled result holds the sequencer in its output step.

module matrix_multiply_unit import mmu_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  mmu_item_if.sink   item,
  mmu_result_if.source result,
  mmu_cfg_if.sink    cfg
);

  localparam int IdxW  = $clog2(MAX_DIM);
  localparam int AddrW = 2 * IdxW;

  logic [CFG_DATA_W-1:0]   rows_of_a;
  logic [CFG_DATA_W-1:0]   inner_size;
  logic [CFG_DATA_W-1:0]   cols_of_b;

  logic                    item_accept;
  logic                    in_range;
  logic                    we_a;
  logic                    we_b;
  logic                    start;
  logic [AddrW-1:0]        waddr;
  logic [AddrW-1:0]        a_raddr;
  logic [AddrW-1:0]        b_raddr;
  logic [ELEM_WIDTH-1:0]   a_data;
  logic [ELEM_WIDTH-1:0]   b_data;
  mac_ctl_t                ctl;
  logic                    mac_done;
  logic signed [PROD_W-1:0] mac_result;
  logic                    idle;
  logic                    emit;
  logic                    emit_last;
  logic                    out_free;
  logic [IdxW-1:0]         cur_row;
  logic [IdxW-1:0]         cur_col;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a  <= DIM_RESET;
      inner_size <= DIM_RESET;
      cols_of_b  <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_ROWS_OF_A:  rows_of_a  <= cfg.data;
        REG_INNER_SIZE: inner_size <= cfg.data;
        REG_COLS_OF_B:  cols_of_b  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign item.ready  = idle;
  assign item_accept = item.valid && item.ready;
  assign in_range    = (32'(item.row_index) < MAX_DIM) && (32'(item.col_index) < MAX_DIM);
  assign we_a        = item_accept && in_range && (item.command == CMD_LOAD_A);
  assign we_b        = item_accept && in_range && (item.command == CMD_LOAD_B);
  assign start       = item_accept && (item.command == CMD_COMPUTE);
  assign waddr       = {IdxW'(item.row_index), IdxW'(item.col_index)};

  mmu_store #(
    .ADDR_W (AddrW),
    .DATA_W (ELEM_WIDTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (item.element_value),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  mmu_store #(
    .ADDR_W (AddrW),
    .DATA_W (ELEM_WIDTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (item.element_value),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  mmu_seq #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IdxW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .rows_of_a  (rows_of_a),
    .inner_size (inner_size),
    .cols_of_b  (cols_of_b),
    .acc_done   (mac_done),
    .out_free   (out_free),
    .idle       (idle),
    .a_raddr    (a_raddr),
    .b_raddr    (b_raddr),
    .ctl        (ctl),
    .emit       (emit),
    .cur_row    (cur_row),
    .cur_col    (cur_col),
    .emit_last  (emit_last)
  );

  mmu_mac #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .IDX_W      (IdxW)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .a_data (a_data),
    .b_data (b_data),
    .done   (mac_done),
    .result (mac_result)
  );

  assign out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_row       <= IDX_PORT_W'(cur_row);
      result.out_col       <= IDX_PORT_W'(cur_col);
      result.product_value <= mac_result;
      result.last          <= emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_emit_into_free_slot : assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result register overwritten while a result is waiting");

  a_compute_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    start |=> !item.ready)
    else $error("compute request did not start the sequencer");

  a_last_returns_idle : assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> item.ready)
    else $error("sequencer did not return to idle after the final element");

  a_done_not_idle : assert property (@(posedge clk) disable iff (rst)
    mac_done |-> !item.ready)
    else $error("accumulator finished while the sequencer was idle");
`endif

endmodule

[tb/mmu_scoreboard_pkg.sv]
`timescale 1ns / 1ps

package mmu_scoreboard_pkg;
  import mmu_pkg::*;

  localparam int MATRIX_DIM = 8;
  localparam int ELEM_W     = 16;

  localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_PORT_W-1:0]    row_index;
    logic [IDX_PORT_W-1:0]    col_index;
    logic signed [ELEM_W-1:0] element_value;
  } mmu_request_t;

  typedef struct packed {
    logic [IDX_PORT_W-1:0]    out_row;
    logic [IDX_PORT_W-1:0]    out_col;
    logic signed [PROD_W-1:0] product_value;
    logic                     last;
  } product_elem_t;

  // A register value of zero behaves as one, anything above the store size as the size.
  function automatic int unsigned dim_in_use(logic [CFG_DATA_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MATRIX_DIM) return MATRIX_DIM;
    return raw;
  endfunction

  class product_scoreboard;
    logic signed [ELEM_W-1:0] mat_a [MATRIX_DIM*MATRIX_DIM];
    logic signed [ELEM_W-1:0] mat_b [MATRIX_DIM*MATRIX_DIM];
    logic [CFG_DATA_W-1:0]    rows_reg;
    logic [CFG_DATA_W-1:0]    inner_reg;
    logic [CFG_DATA_W-1:0]    cols_reg;
    product_elem_t            product_q[$];
    int                       errors;
    int                       checked;
    int                       runs;

    function new();
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      errors    = 0;
      checked   = 0;
      runs      = 0;
    endfunction

    function int unsigned pending();
      return product_q.size();
    endfunction

    function void note_config(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ROWS_OF_A:  rows_reg = val;
        REG_INNER_SIZE: inner_reg = val;
        REG_COLS_OF_B:  cols_reg = val;
        default: ;
      endcase
    endfunction

    function void queue_products();
      int unsigned   m;
      int unsigned   n;
      int unsigned   p;
      longint        acc;
      product_elem_t elem;
      m = dim_in_use(rows_reg);
      n = dim_in_use(inner_reg);
      p = dim_in_use(cols_reg);
      runs++;
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < p; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'(mat_a[i*MATRIX_DIM+k]) * longint'(mat_b[k*MATRIX_DIM+j]);
          if (acc > SUM_MAX) acc = SUM_MAX;
          if (acc < SUM_MIN) acc = SUM_MIN;
          elem.out_row       = IDX_PORT_W'(i);
          elem.out_col       = IDX_PORT_W'(j);
          elem.product_value = acc[PROD_W-1:0];
          elem.last          = (i == m - 1) && (j == p - 1);
          product_q = {product_q, elem};
        end
      end
    endfunction

    function void note_request(mmu_request_t req);
      int unsigned addr;
      addr = req.row_index * MATRIX_DIM + req.col_index;
      if (req.command == CMD_LOAD_A) mat_a[addr] = req.element_value;
      else if (req.command == CMD_LOAD_B) mat_b[addr] = req.element_value;
      else if (req.command == CMD_COMPUTE) queue_products();
    endfunction

    function void check_result(product_elem_t got);
      product_elem_t want;
      if (product_q.size() == 0) begin
        $error("product element row %0d col %0d arrived with none outstanding",
               got.out_row, got.out_col);
        errors++;
        return;
      end
      want = product_q.pop_front();
      checked++;
      if (got.out_row !== want.out_row) begin
        $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== want.out_col) begin
        $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
        errors++;
      end
      if (got.product_value !== want.product_value) begin
        $error("product_value: expected %0d, got %0d", want.product_value, got.product_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import mmu_pkg::*;
  import mmu_scoreboard_pkg::*;

  localparam int ITEM_TARGET  = 520;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;

  logic clk;
  logic rst;

  mmu_item_if #(.ELEM_WIDTH(ELEM_W)) item_ch ();
  mmu_result_if                     result_ch ();
  mmu_cfg_if                        cfg_ch ();

  matrix_multiply_unit #(.MAX_DIM(MATRIX_DIM), .ELEM_WIDTH(ELEM_W)) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  product_scoreboard sb;

  int          src_idle_pct;
  int          sink_idle_pct;
  int          items_sent;
  int          stall_cycles;
  int          dim_settings;
  int unsigned rows_in_use;
  int unsigned inner_in_use;
  int unsigned cols_in_use;
  bit          a_loaded [MATRIX_DIM*MATRIX_DIM];
  bit          b_loaded [MATRIX_DIM*MATRIX_DIM];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    mmu_request_t  req;
    product_elem_t elem;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        req.command       = item_ch.command;
        req.row_index     = item_ch.row_index;
        req.col_index     = item_ch.col_index;
        req.element_value = item_ch.element_value;
        sb.note_request(req);
      end
      if (result_ch.valid && result_ch.ready) begin
        elem.out_row       = result_ch.out_row;
        elem.out_col       = result_ch.out_col;
        elem.product_value = result_ch.product_value;
        elem.last          = result_ch.last;
        sb.check_result(elem);
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.note_config(cfg_ch.addr, cfg_ch.data);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("matrix_multiply_unit regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0100;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return CFG_DATA_W'($urandom_range(1, 3));
    if (roll < 85) return CFG_DATA_W'($urandom_range(4, 8));
    roll = $urandom_range(8);
    return (roll == 0) ? CFG_DATA_W'(0) : CFG_DATA_W'(roll + 7);
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] command,
                           input logic [IDX_PORT_W-1:0] row,
                           input logic [IDX_PORT_W-1:0] col,
                           input logic signed [ELEM_W-1:0] value);
    int unsigned addr;
    addr = row * MATRIX_DIM + col;
    if (items_sent < ITEM_TARGET / 3) begin
      src_idle_pct  = 28;
      sink_idle_pct = 69;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      src_idle_pct  = 69;
      sink_idle_pct = 28;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
    if ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    item_ch.valid         <= 1'b1;
    item_ch.command       <= command;
    item_ch.row_index     <= row;
    item_ch.col_index     <= col;
    item_ch.element_value <= value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (command == CMD_LOAD_A) a_loaded[addr] = 1'b1;
    else if (command == CMD_LOAD_B) b_loaded[addr] = 1'b1;
    if (command != CMD_UNUSED) items_sent++;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows, inner, cols,
                           input bit poke_unused);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_ROWS_OF_A, REG_INNER_SIZE, REG_COLS_OF_B, REG_UNUSED};
    val = '{rows, inner, cols, CFG_DATA_W'($urandom)};
    for (int w = 0; w < (poke_unused ? 4 : 3); w++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr  <= idx[w];
      cfg_ch.data  <= val[w];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    rows_in_use  = dim_in_use(rows);
    inner_in_use = dim_in_use(inner);
    cols_in_use  = dim_in_use(cols);
    dim_settings++;
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Every element read by the next product request is loaded at least once first.
  task automatic run_product_sequence();
    logic [CMD_W-1:0] noise_cmd;
    repeat ($urandom_range(3)) begin
      case ($urandom_range(5))
        0:       noise_cmd = CMD_UNUSED;
        1, 2:    noise_cmd = CMD_LOAD_A;
        default: noise_cmd = CMD_LOAD_B;
      endcase
      send_item(noise_cmd, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom), pick_element());
    end
    for (int r = 0; r < rows_in_use; r++)
      for (int k = 0; k < inner_in_use; k++)
        if (!a_loaded[r*MATRIX_DIM+k] || $urandom_range(9) == 0)
          send_item(CMD_LOAD_A, IDX_PORT_W'(r), IDX_PORT_W'(k), pick_element());
    for (int k = 0; k < inner_in_use; k++)
      for (int c = 0; c < cols_in_use; c++)
        if (!b_loaded[k*MATRIX_DIM+c] || $urandom_range(9) == 0)
          send_item(CMD_LOAD_B, IDX_PORT_W'(k), IDX_PORT_W'(c), pick_element());
    send_item(CMD_COMPUTE, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom), pick_element());
    if ($urandom_range(7) == 0)
      send_item(CMD_COMPUTE, IDX_PORT_W'($urandom), IDX_PORT_W'($urandom), pick_element());
    if ($urandom_range(9) == 0) wait_drained();
  endtask

  initial begin
    int phase;
    sb                    = new();
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.command       = CMD_LOAD_A;
    item_ch.row_index     = '0;
    item_ch.col_index     = '0;
    item_ch.element_value = '0;
    result_ch.ready       = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.addr           = REG_ROWS_OF_A;
    cfg_ch.data           = '0;
    src_idle_pct          = 28;
    sink_idle_pct         = 69;
    items_sent            = 0;
    stall_cycles          = 0;
    dim_settings          = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A zero row count acts as one row; sums of full-scale products hit both rails.
    configure(4'd0, 4'd3, 4'd2, 1'b1);
    for (int k = 0; k < 3; k++) begin
      send_item(CMD_LOAD_A, 3'd0, IDX_PORT_W'(k), 16'sh8000);
      send_item(CMD_LOAD_B, IDX_PORT_W'(k), 3'd0, 16'sh8000);
      send_item(CMD_LOAD_B, IDX_PORT_W'(k), 3'd1, 16'sh7FFF);
    end
    send_item(CMD_UNUSED, 3'd0, 3'd0, 16'sh1234);
    send_item(CMD_COMPUTE, 3'd7, 3'd7, 16'sh7FFF);
    send_item(CMD_LOAD_A, 3'd7, 3'd7, 16'sh7FFF);
    send_item(CMD_LOAD_B, 3'd7, 3'd7, 16'sh8000);
    send_item(CMD_LOAD_A, 3'd0, 3'd1, 16'sh0000);
    send_item(CMD_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    send_item(CMD_LOAD_A, 3'd0, 3'd2, 16'sh0100);
    send_item(CMD_COMPUTE, 3'd5, 3'd2, 16'shFFFF);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      case (phase)
        0:       configure(4'd15, 4'd8, 4'd12, 1'b0);
        1:       configure(4'd1, 4'd0, 4'd1, 1'b0);
        default: configure(pick_dim(), pick_dim(), pick_dim(), 1'b0);
      endcase
      repeat ($urandom_range(1, 4))
        if (items_sent < ITEM_TARGET) run_product_sequence();
      phase++;
    end
    wait_drained();

    $display("Sent %0d load and product requests over %0d dimension settings, 1x1x1 to 8x8x8.",
             items_sent, dim_settings);
    $display("Checked %0d product elements from %0d product runs, saturating at both rails.",
             sb.checked, sb.runs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("matrix_multiply_unit regression: pass");
    end else begin
      $display("matrix_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule
